>>> sv/mate_methylation_merge_count_core_assert.svh
// Assertion macros for the methylation merge and count block.
`ifndef MATE_METHYLATION_MERGE_COUNT_CORE_ASSERT_SVH
`define MATE_METHYLATION_MERGE_COUNT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MMMC_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mmmc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MMMC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mmmc assertion failed");

`endif

>>> sv/mmmc_pkg.sv
// Shared types and constants of the methylation merge and count block.
`timescale 1ns / 1ps

package mmmc_pkg;

  // Widest site address the queue entries carry (sites up to 4096).
  localparam int unsigned ADDR_W_MAX = 12;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_SYMBOL = 1'b1;

  localparam logic [1:0] SYM_UNKNOWN = 2'd0;
  localparam logic [1:0] SYM_METH    = 2'd1;
  localparam logic [1:0] SYM_UNMETH  = 2'd2;

  typedef enum logic [1:0] {
    STATUS_GOOD    = 2'd0,
    STATUS_SHORT   = 2'd1,
    STATUS_INVALID = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_REPORT = 2'd2
  } cmd_e;

  typedef struct packed {
    cmd_e                  op;
    logic [ADDR_W_MAX-1:0] site;
    logic [1:0]            sym;
    logic                  last;
    logic                  span_err;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

>>> sv/mmmc_if.sv
// Request channel interfaces of the methylation merge and count block.
`timescale 1ns / 1ps

interface mmmc_in_if #(
  parameter int unsigned IDX_W = 28
) ();
  logic             valid;
  logic             ready;
  logic             operation;
  logic [IDX_W-1:0] start_first;
  logic [IDX_W-1:0] start_second;
  logic [8:0]       len_first;
  logic [8:0]       len_second;
  logic             mate;
  logic [7:0]       position;
  logic [1:0]       symbol;
  logic             last;

  modport source (
    output valid, operation, start_first, start_second, len_first, len_second,
           mate, position, symbol, last,
    input  ready
  );
  modport sink (
    input  valid, operation, start_first, start_second, len_first, len_second,
           mate, position, symbol, last,
    output ready
  );
endinterface

interface mmmc_out_if ();
  logic       valid;
  logic       ready;
  logic [8:0] count_meth;
  logic [8:0] count_unmeth;
  logic [1:0] status;

  modport source (
    output valid, count_meth, count_unmeth, status,
    input  ready
  );
  modport sink (
    input  valid, count_meth, count_unmeth, status,
    output ready
  );
endinterface

>>> sv/mmmc_front.sv
// Front end: accepts requests, tracks the pair geometry and classifies symbols.
`timescale 1ns / 1ps

module mmmc_front
  import mmmc_pkg::*;
#(
  parameter int unsigned MAX_SPAN = 256,
  parameter int unsigned IDX_W    = 28
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mmmc_in_if.sink      in_i,
  input  fifo_status_t fifo_status_i,
  output logic         push_o,
  output cmd_t         cmd_o
);

  localparam int unsigned SW   = $clog2(MAX_SPAN);
  localparam int unsigned SUMW = ((SW > 8) ? SW : 8) + 1;

  logic [8:0]    len_first_q, len_first_d;
  logic [8:0]    len_second_q, len_second_d;
  logic [SW-1:0] off_first_q, off_first_d;
  logic [SW-1:0] off_second_q, off_second_d;
  logic          span_err_q, span_err_d;

  logic             accept;
  logic             is_header;
  logic             first_le;
  logic             both_present;
  logic [IDX_W-1:0] diff;
  logic [8:0]       len_early, len_late;
  logic [IDX_W:0]   far_end;
  logic             span_err_new;
  logic [8:0]       sym_len;
  logic [SW-1:0]    sym_off;
  logic [SUMW-1:0]  site;
  logic [1:0]       sym_norm;
  logic             write_ok;

  assign in_i.ready = !fifo_status_i.full;
  assign accept     = in_i.valid && !fifo_status_i.full;
  assign is_header  = (in_i.operation == OP_HEADER);

  // Header geometry: distance between starts, then the far end seen from the earlier one.
  always_comb begin
    first_le     = (in_i.start_first <= in_i.start_second);
    diff         = first_le ? (in_i.start_second - in_i.start_first)
                            : (in_i.start_first - in_i.start_second);
    len_early    = first_le ? in_i.len_first : in_i.len_second;
    len_late     = first_le ? in_i.len_second : in_i.len_first;
    both_present = (in_i.len_first != 9'd0) && (in_i.len_second != 9'd0);
    far_end      = {1'b0, diff} + (IDX_W+1)'(len_late);
    span_err_new = both_present &&
                   ((far_end > (IDX_W+1)'(MAX_SPAN)) ||
                    ((IDX_W+1)'(len_early) > (IDX_W+1)'(MAX_SPAN)));
  end

  // Symbol classification against the current pair.
  always_comb begin
    sym_len  = in_i.mate ? len_second_q : len_first_q;
    sym_off  = in_i.mate ? off_second_q : off_first_q;
    site     = SUMW'(sym_off) + SUMW'(in_i.position);
    sym_norm = (in_i.symbol == 2'd3) ? SYM_UNKNOWN : in_i.symbol;
    write_ok = !span_err_q && ({1'b0, in_i.position} < sym_len) &&
               (site < SUMW'(MAX_SPAN));
  end

  always_comb begin
    cmd_o.op       = is_header ? CMD_CLEAR : (write_ok ? CMD_WRITE : CMD_REPORT);
    cmd_o.site     = ADDR_W_MAX'(site);
    cmd_o.sym      = sym_norm;
    cmd_o.last     = in_i.last;
    cmd_o.span_err = span_err_new;
    push_o         = accept && (is_header || write_ok || in_i.last);
  end

  always_comb begin
    len_first_d  = len_first_q;
    len_second_d = len_second_q;
    off_first_d  = off_first_q;
    off_second_d = off_second_q;
    span_err_d   = span_err_q;
    if (accept && is_header) begin
      len_first_d  = in_i.len_first;
      len_second_d = in_i.len_second;
      span_err_d   = span_err_new;
      off_first_d  = '0;
      off_second_d = '0;
      if (both_present) begin
        off_first_d  = first_le ? '0 : SW'(diff);
        off_second_d = first_le ? SW'(diff) : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_first_q  <= '0;
      len_second_q <= '0;
      off_first_q  <= '0;
      off_second_q <= '0;
      span_err_q   <= 1'b0;
    end else begin
      len_first_q  <= len_first_d;
      len_second_q <= len_second_d;
      off_first_q  <= off_first_d;
      off_second_q <= off_second_d;
      span_err_q   <= span_err_d;
    end
  end

endmodule

>>> sv/mmmc_fifo.sv
// Small register queue between the front end and the back end.
`timescale 1ns / 1ps

module mmmc_fifo
  import mmmc_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output fifo_status_t     status_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] regs_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;

  assign data_o         = regs_q[rd_ptr_q];
  assign status_o.full  = (count_q == CW'(DEPTH));
  assign status_o.empty = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      regs_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

>>> sv/mmmc_back.sv
// Back end: site memory, merge of mate calls, running counts and result register.
`timescale 1ns / 1ps

module mmmc_back
  import mmmc_pkg::*;
#(
  parameter int unsigned MAX_SPAN = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmd_t         cmd_i,
  input  fifo_status_t fifo_status_i,
  input  logic [8:0]   min_sites_i,
  output logic         pop_o,
  mmmc_out_if.source   out_o
);

  localparam int unsigned SW = $clog2(MAX_SPAN);
  localparam int unsigned CW = $clog2(MAX_SPAN + 1);
  localparam int unsigned SC = ((CW + 1) > 9) ? (CW + 1) : 9;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_e;

  state_e state_q, state_d;
  cmd_t   entry_q;

  logic [1:0]          mem_q [MAX_SPAN];
  logic [1:0]          rd_data_q;
  logic [MAX_SPAN-1:0] valid_q;
  logic [CW-1:0]       meth_q, meth_d;
  logic [CW-1:0]       unmeth_q, unmeth_d;
  logic                err_q, err_d;

  logic       out_valid_q;
  logic [8:0] out_meth_q, out_unmeth_q;
  status_e    out_status_q;

  logic [SW-1:0] head_addr, entry_addr;
  logic [1:0]    old_val, upd_val;
  logic          mem_we, clear_valid, set_valid, emit;
  logic [SC-1:0] known_sum;
  status_e       status_new;

  assign head_addr  = cmd_i.site[SW-1:0];
  assign entry_addr = entry_q.site[SW-1:0];

  assign pop_o = (state_q == ST_IDLE) && !fifo_status_i.empty &&
                 (!cmd_i.last || !out_valid_q || out_o.ready);

  // A site never written since the last header reads as unknown.
  always_comb begin
    old_val = valid_q[entry_addr] ? rd_data_q : SYM_UNKNOWN;
    if (old_val == SYM_UNKNOWN) begin
      upd_val = entry_q.sym;
    end else if ((entry_q.sym == SYM_UNKNOWN) || (entry_q.sym == old_val)) begin
      upd_val = old_val;
    end else begin
      upd_val = SYM_UNKNOWN;
    end
  end

  always_comb begin
    state_d     = state_q;
    meth_d      = meth_q;
    unmeth_d    = unmeth_q;
    err_d       = err_q;
    mem_we      = 1'b0;
    clear_valid = 1'b0;
    set_valid   = 1'b0;
    emit        = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          case (cmd_i.op)
            CMD_CLEAR: begin
              meth_d      = '0;
              unmeth_d    = '0;
              err_d       = cmd_i.span_err;
              clear_valid = 1'b1;
              emit        = cmd_i.last;
            end
            CMD_WRITE: begin
              state_d = ST_MERGE;
            end
            default: begin
              emit = cmd_i.last;
            end
          endcase
        end
      end
      ST_MERGE: begin
        mem_we    = 1'b1;
        set_valid = 1'b1;
        meth_d    = meth_q + CW'(upd_val == SYM_METH) - CW'(old_val == SYM_METH);
        unmeth_d  = unmeth_q + CW'(upd_val == SYM_UNMETH) - CW'(old_val == SYM_UNMETH);
        emit      = entry_q.last;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    known_sum = SC'(meth_d) + SC'(unmeth_d);
    if (err_d) begin
      status_new = STATUS_INVALID;
    end else if (known_sum < SC'(min_sites_i)) begin
      status_new = STATUS_SHORT;
    end else begin
      status_new = STATUS_GOOD;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_data_q <= mem_q[head_addr];
    end
    if (mem_we) begin
      mem_q[entry_addr] <= upd_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      entry_q      <= '0;
      valid_q      <= '0;
      meth_q       <= '0;
      unmeth_q     <= '0;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_meth_q   <= '0;
      out_unmeth_q <= '0;
      out_status_q <= STATUS_GOOD;
    end else begin
      state_q  <= state_d;
      meth_q   <= meth_d;
      unmeth_q <= unmeth_d;
      err_q    <= err_d;
      if (pop_o) begin
        entry_q <= cmd_i;
      end
      if (clear_valid) begin
        valid_q <= '0;
      end else if (set_valid) begin
        valid_q[entry_addr] <= 1'b1;
      end
      if (emit) begin
        out_valid_q  <= 1'b1;
        out_meth_q   <= err_d ? 9'd0 : 9'(meth_d);
        out_unmeth_q <= err_d ? 9'd0 : 9'(unmeth_d);
        out_status_q <= status_new;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.count_meth   = out_meth_q;
  assign out_o.count_unmeth = out_unmeth_q;
  assign out_o.status       = out_status_q;

endmodule

>>> sv/mate_methylation_merge_count_core.sv
// Top level of the mate-read methylation merge and count block.
// This block merges the per-site methylation calls of two mate reads and
// counts methylated and unmethylated sites; a header request sets the
// geometry of a pair and a request with last set yields one result. The
// front end accepts one request per cycle while its four-entry queue has
// room, and symbols that fall outside their read or the site window cost
// no further time. The back end sets the sustained rate: a stored symbol
// passes through the registered read of the site memory and then the
// merge and write back before another request is popped; a header or a
// last-only request is handled as it is popped. A header clears the whole
// site window at once through a valid bit per site, so no clearing pass
// follows reset. The result waits in an output register, and the back end
// keeps working until it reaches another request with last set.
`timescale 1ns / 1ps

`include "mate_methylation_merge_count_core_assert.svh"

module mate_methylation_merge_count_core
  import mmmc_pkg::*;
#(
  parameter int unsigned MAX_SPAN        = 256,
  parameter int unsigned SITE_INDEX_BITS = 28
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmmc_in_if.sink    in_i,
  mmmc_out_if.source out_o,
  input  logic       min_sites_we_i,
  input  logic [8:0] min_sites_i
);

  // Queue depth between the two halves; enough to absorb a burst of headers.
  localparam int unsigned QUEUE_DEPTH = 4;

  logic [8:0]   min_sites_q;
  logic         fifo_push, fifo_pop;
  cmd_t         push_cmd;
  logic [$bits(cmd_t)-1:0] fifo_rdata;
  fifo_status_t fifo_status;

  // The user must see that the threshold register is only written while the block is idle
  // (the block does not enforce it), so the back end may read it directly when it forms a status.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sites_q <= 9'd1;
    end else if (min_sites_we_i) begin
      min_sites_q <= min_sites_i;
    end
  end

  // The front end owns the pair lengths and offsets, since every symbol
  // request must be classified against the header that preceded it.
  mmmc_front #(
    .MAX_SPAN (MAX_SPAN),
    .IDX_W    (SITE_INDEX_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .fifo_status_i (fifo_status),
    .push_o        (fifo_push),
    .cmd_o         (push_cmd)
  );

  mmmc_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (fifo_push),
    .data_i   (push_cmd),
    .pop_i    (fifo_pop),
    .data_o   (fifo_rdata),
    .status_o (fifo_status)
  );

  // The back end owns the site memory and the running totals.
  mmmc_back #(
    .MAX_SPAN (MAX_SPAN)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_t'(fifo_rdata)),
    .fifo_status_i (fifo_status),
    .min_sites_i   (min_sites_q),
    .pop_o         (fifo_pop),
    .out_o         (out_o)
  );

  // The front end must never overrun the queue, nor the back end drain an empty one.
  `MMMC_ASSERT_IMPL(a_no_push_when_full, clk_i, rst_ni, fifo_push, !fifo_status.full)
  `MMMC_ASSERT_IMPL(a_no_pop_when_empty, clk_i, rst_ni, fifo_pop, !fifo_status.empty)
  // A push that is not matched by a pop leaves at least one entry behind.
  `MMMC_ASSERT_NEXT(a_push_fills_queue, clk_i, rst_ni, fifo_push && !fifo_pop, !fifo_status.empty)
  // An invalid span always reports zero counts.
  `MMMC_ASSERT_IMPL(a_invalid_zero_counts, clk_i, rst_ni,
    out_o.valid && (out_o.status == STATUS_INVALID),
    (out_o.count_meth == 9'd0) && (out_o.count_unmeth == 9'd0))

endmodule
